// File: rtl/biquad_lowpass_filter_bank_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the biquad low-pass filter bank
// Concurrent checks clocked by clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_LOWPASS_FILTER_BANK_TOP_ASSERT_SVH
`define BIQUAD_LOWPASS_FILTER_BANK_TOP_ASSERT_SVH

`ifndef SYNTH

// ante in one cycle implies cons in the same cycle
`define BQLP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante in one cycle implies cons in the next cycle
`define BQLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// cond never holds
`define BQLP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define BQLP_ASSERT_IMPLY(label, ante, cons, msg)
`define BQLP_ASSERT_NEXT(label, ante, cons, msg)
`define BQLP_ASSERT_NEVER(label, cond, msg)

`endif

`endif

// File: rtl/bqlp_pkg.sv
// ----------------------------------------------------------------------------
// bqlp_pkg
// Coefficient formats, register indexes and reset values of the filter bank.
// ----------------------------------------------------------------------------
`default_nettype none

package bqlp_pkg;

  localparam int COEF_BITS    = 27;
  localparam int COEF_FRAC    = 24;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GYRO_B0  = 3'd0,
    REG_GYRO_A1  = 3'd1,
    REG_GYRO_A2  = 3'd2,
    REG_ACCEL_B0 = 3'd3,
    REG_ACCEL_A1 = 3'd4,
    REG_ACCEL_A2 = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } coef_set_t;

  typedef struct packed {
    coef_set_t gyro;
    coef_set_t accel;
  } coef_bank_t;

  localparam coef_bank_t COEF_RST = '{
    gyro:  '{b0: 27'sd9030, a1: -27'sd32435400, a2: 27'sd15694353},
    accel: '{b0: 27'sd2295, a1: -27'sd32994797, a2: 27'sd16226733}
  };

endpackage

`default_nettype wire

// File: rtl/biquad_lowpass_filter_bank_top.sv
// ----------------------------------------------------------------------------
// biquad_lowpass_filter_bank_top
// Multi-channel Direct Form I low-pass biquad bank, state kept in one RAM.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  in_      in   in_tvalid / in_tready   tuser: channel, tdata: sample_in
//  out_     out  out_tvalid / out_tready tuser: channel_out, tdata: sample_out
//  cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data (coefficient)
//
//  out_tvalid rises once an accepted item has passed stages 1-3 and the
//  output register. Items for different channels go in one per cycle
//  while out_tready does not hold the output; an item for a channel still in
//  flight waits until its predecessor has written the state RAM back (read-multiply-sum-write loop).
//  Reset loads default coefficients and marks all RAM entries empty (they
//  read as zero); no clearing pass. out_tready low holds the output register
//  and the stages behind it fill up before in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "biquad_lowpass_filter_bank_top_assert.svh"

module biquad_lowpass_filter_bank_top #(
  parameter int NUM_CHANNELS = 6,
  parameter int SAMPLE_BITS  = 24,
  localparam int CLOG_CH     = $clog2(NUM_CHANNELS),
  localparam int CH_W        = (CLOG_CH > 3) ? CLOG_CH : 3,
  localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input items
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [CH_W-1:0]                   in_tuser,   // channel
  input  wire logic [DATA_W-1:0]                 in_tdata,   // sample_in, zero fill
  // result items
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [CH_W-1:0]                        out_tuser,  // channel_out
  output logic [DATA_W-1:0]                      out_tdata,  // sample_out, zero fill
  // coefficient writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bqlp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [bqlp_pkg::COEF_BITS-1:0]    cfg_data
);
  import bqlp_pkg::*;

  localparam int ADDR_W = CLOG_CH;
  localparam int SB     = SAMPLE_BITS;
  localparam int EW     = 4 * SB;
  localparam int PW     = COEF_BITS + SB;
  localparam int SW     = SB + 30;

  localparam logic [CH_W:0] NCH  = (CH_W + 1)'(NUM_CHANNELS);
  localparam logic [CH_W:0] HALF = (CH_W + 1)'(NUM_CHANNELS / 2);

  localparam logic signed [SW-1:0] RND_C = SW'(64'sd1 <<< (COEF_FRAC - 1));
  localparam logic signed [SW-1:0] SMAX  = SW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SMIN  = SW'(-(64'sd1 <<< (SB - 1)));

  coef_bank_t coefs;

  bqlp_coef_regs u_coef_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  // ---------------- pipeline control ----------------
  logic              s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic              s1_inr_r, s2_inr_r, s3_inr_r;
  logic [CH_W-1:0]   s1_ch_r, s2_ch_r, s3_ch_r, out_ch_r;
  logic              out_en, ld3, ld2, ld1;
  logic              acc_in, in_inr, hazard;
  logic [CH_W-1:0]   in_ch;

  assign out_en = !out_valid_r || out_tready;
  assign ld3    = !s3_valid_r || out_en;
  assign ld2    = !s2_valid_r || ld3;
  assign ld1    = !s1_valid_r || ld2;

  assign in_ch  = in_tuser;
  assign in_inr = {1'b0, in_ch} < NCH;

  // a channel with an item in flight is read only after its write-back
  assign hazard = in_inr && (
                  (s1_valid_r && s1_inr_r && (s1_ch_r == in_ch)) ||
                  (s2_valid_r && s2_inr_r && (s2_ch_r == in_ch)) ||
                  (s3_valid_r && s3_inr_r && (s3_ch_r == in_ch)));

  assign in_tready = ld1 && !hazard;
  assign acc_in    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1)    s1_valid_r  <= acc_in;
      if (ld2)    s2_valid_r  <= s1_valid_r;
      if (ld3)    s3_valid_r  <= s2_valid_r;
      if (out_en) out_valid_r <= s3_valid_r;
    end
  end

  // ---------------- state RAM ----------------
  // entry: {y2, y1, x2, x1}
  logic [EW-1:0]          mem_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] ent_vld_r;
  logic [EW-1:0]          rd_data_r;
  logic                   rd_vld_r;
  logic                   rd_en, wr_en;
  logic [ADDR_W-1:0]      raddr, waddr;
  logic [EW-1:0]          wr_data;

  assign rd_en = acc_in && in_inr;
  assign raddr = in_ch[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[waddr] <= wr_data;
    if (rd_en) begin
      rd_data_r <= mem_r[raddr];
      rd_vld_r  <= ent_vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (wr_en) begin
      ent_vld_r[waddr] <= 1'b1;
    end
  end

  // ---------------- stage 1: coefficient select and products ----------------
  logic signed [SB-1:0] s1_x_r;
  logic signed [SB-1:0] s1_x1, s1_x2, s1_y1, s1_y2;
  logic [EW-1:0]        s1_ent;
  coef_set_t            s1_set;
  logic signed [COEF_BITS-1:0] b0, a1, a2;
  logic signed [PW-1:0] p0_nxt, p1_nxt, p2_nxt, p3_nxt, p4_nxt;

  always_ff @(posedge clk) begin
    if (ld1 && acc_in) begin
      s1_ch_r  <= in_ch;
      s1_inr_r <= in_inr;
      s1_x_r   <= in_tdata[SB-1:0];
    end
  end

  assign s1_ent = rd_vld_r ? rd_data_r : '0;   // never-written entry reads zero
  assign s1_x1  = s1_ent[SB-1:0];
  assign s1_x2  = s1_ent[2*SB-1:SB];
  assign s1_y1  = s1_ent[3*SB-1:2*SB];
  assign s1_y2  = s1_ent[4*SB-1:3*SB];

  assign s1_set = ({1'b0, s1_ch_r} < HALF) ? coefs.gyro : coefs.accel;
  assign b0     = s1_set.b0;
  assign a1     = s1_set.a1;
  assign a2     = s1_set.a2;

  assign p0_nxt = b0 * s1_x_r;
  assign p1_nxt = b0 * s1_x1;
  assign p2_nxt = b0 * s1_x2;
  assign p3_nxt = a1 * s1_y1;
  assign p4_nxt = a2 * s1_y2;

  // ---------------- stage 2: sum ----------------
  logic signed [PW-1:0] s2_p0_r, s2_p1_r, s2_p2_r, s2_p3_r, s2_p4_r;
  logic signed [SB-1:0] s2_x_r, s2_x1_r, s2_y1_r;
  logic signed [SW-1:0] sum_nxt;

  always_ff @(posedge clk) begin
    if (ld2 && s1_valid_r) begin
      s2_ch_r  <= s1_ch_r;
      s2_inr_r <= s1_inr_r;
      s2_x_r   <= s1_x_r;
      s2_x1_r  <= s1_x1;
      s2_y1_r  <= s1_y1;
      s2_p0_r  <= p0_nxt;
      s2_p1_r  <= p1_nxt;
      s2_p2_r  <= p2_nxt;
      s2_p3_r  <= p3_nxt;
      s2_p4_r  <= p4_nxt;
    end
  end

  // b1 = 2*b0 folded in as a shift
  assign sum_nxt = SW'(s2_p0_r) + (SW'(s2_p1_r) <<< 1) + SW'(s2_p2_r)
                 - SW'(s2_p3_r) - SW'(s2_p4_r);

  // ---------------- stage 3: round, saturate, write back ----------------
  logic signed [SW-1:0] s3_sum_r;
  logic signed [SB-1:0] s3_x_r, s3_x1_r, s3_y1_r;
  logic signed [SW-1:0] rnd, quo;
  logic signed [SB-1:0] y_sat;
  logic [SB-1:0]        out_sample_r;

  always_ff @(posedge clk) begin
    if (ld3 && s2_valid_r) begin
      s3_ch_r  <= s2_ch_r;
      s3_inr_r <= s2_inr_r;
      s3_x_r   <= s2_x_r;
      s3_x1_r  <= s2_x1_r;
      s3_y1_r  <= s2_y1_r;
      s3_sum_r <= sum_nxt;
    end
  end

  // round half up, then floor by the coefficient scale
  assign rnd = s3_sum_r + RND_C;
  assign quo = rnd >>> COEF_FRAC;

  always_comb begin
    if (quo > SMAX) begin
      y_sat = SMAX[SB-1:0];
    end else if (quo < SMIN) begin
      y_sat = SMIN[SB-1:0];
    end else begin
      y_sat = quo[SB-1:0];
    end
  end

  assign wr_en   = s3_valid_r && s3_inr_r && out_en;
  assign waddr   = s3_ch_r[ADDR_W-1:0];
  assign wr_data = {s3_y1_r, y_sat, s3_x1_r, s3_x_r};

  always_ff @(posedge clk) begin
    if (out_en && s3_valid_r) begin
      out_ch_r     <= s3_ch_r;
      out_sample_r <= s3_inr_r ? y_sat : '0;   // unknown channel returns zero
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ch_r;
  assign out_tdata  = DATA_W'(out_sample_r);

  // ---------------- checks ----------------
  `BQLP_ASSERT_NEVER(a_rw_same_entry, rd_en && wr_en && (raddr == waddr), "RAM read and write hit one entry")
  `BQLP_ASSERT_IMPLY(a_s1_s2_distinct, s1_valid_r && s2_valid_r && s1_inr_r && s2_inr_r, s1_ch_r != s2_ch_r, "same channel in stages 1 and 2")
  `BQLP_ASSERT_IMPLY(a_s1_s3_distinct, s1_valid_r && s3_valid_r && s1_inr_r && s3_inr_r, s1_ch_r != s3_ch_r, "same channel in stages 1 and 3")
  `BQLP_ASSERT_NEXT(a_accept_enters, acc_in, s1_valid_r, "accepted item lost before stage 1")

endmodule

`default_nettype wire

// File: rtl/bqlp_coef_regs.sv
// ----------------------------------------------------------------------------
// bqlp_coef_regs
// Coefficient register file for the gyro and accel sets, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module bqlp_coef_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bqlp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [bqlp_pkg::COEF_BITS-1:0]    cfg_data,
  output bqlp_pkg::coef_bank_t                   coefs
);
  import bqlp_pkg::*;

  coef_bank_t coef_r;
  coef_bank_t coef_nxt;

  assign cfg_ready = 1'b1;
  assign coefs     = coef_r;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_GYRO_B0:  coef_nxt.gyro.b0  = cfg_data;
        REG_GYRO_A1:  coef_nxt.gyro.a1  = cfg_data;
        REG_GYRO_A2:  coef_nxt.gyro.a2  = cfg_data;
        REG_ACCEL_B0: coef_nxt.accel.b0 = cfg_data;
        REG_ACCEL_A1: coef_nxt.accel.a1 = cfg_data;
        REG_ACCEL_A2: coef_nxt.accel.a2 = cfg_data;
        default:      coef_nxt = coef_r;   // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RST;
    end else begin
      coef_r <= coef_nxt;
    end
  end

endmodule

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Filter bank testbench
// Streams channel/sample items through the biquad bank under random bursts
// and output back-pressure, predicts every filtered sample in fixed point and
// compares results in order. Coefficients are reloaded between phases.
// ----------------------------------------------------------------------------

class biquad_checker;
  localparam int NCH       = 6;
  localparam int FRAC      = bqlp_pkg::COEF_FRAC;
  localparam longint HALF  = longint'(1) << (FRAC - 1);
  localparam longint Y_MAX = (longint'(1) << 23) - 1;
  localparam longint Y_MIN = -(longint'(1) << 23);

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [23:0] sample;
  } filtered_t;

  bqlp_pkg::coef_bank_t coefs;
  logic signed [23:0]   x_d1[NCH];
  logic signed [23:0]   x_d2[NCH];
  logic signed [23:0]   y_d1[NCH];
  logic signed [23:0]   y_d2[NCH];
  filtered_t            expected_q[$];
  int                   failures;

  function new();
    coefs    = bqlp_pkg::COEF_RST;
    failures = 0;
    for (int i = 0; i < NCH; i++) begin
      x_d1[i] = '0;
      x_d2[i] = '0;
      y_d1[i] = '0;
      y_d2[i] = '0;
    end
  endfunction

  // indexes past the last register are dropped
  function void load_coef(logic [2:0] idx, logic [26:0] data);
    case (idx)
      bqlp_pkg::REG_GYRO_B0:  coefs.gyro.b0  = data;
      bqlp_pkg::REG_GYRO_A1:  coefs.gyro.a1  = data;
      bqlp_pkg::REG_GYRO_A2:  coefs.gyro.a2  = data;
      bqlp_pkg::REG_ACCEL_B0: coefs.accel.b0 = data;
      bqlp_pkg::REG_ACCEL_A1: coefs.accel.a1 = data;
      bqlp_pkg::REG_ACCEL_A2: coefs.accel.a2 = data;
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void take_sample(logic [2:0] ch, logic signed [23:0] x);
    bqlp_pkg::coef_set_t cs;
    longint              b0, a1, a2, acc, y;
    filtered_t           res;
    res.channel = ch;
    res.sample  = '0;
    if (ch < NCH) begin
      cs  = (ch < NCH / 2) ? coefs.gyro : coefs.accel;
      b0  = longint'($signed(cs.b0));
      a1  = longint'($signed(cs.a1));
      a2  = longint'($signed(cs.a2));
      acc = b0 * longint'(x) + 2 * b0 * longint'(x_d1[ch]) + b0 * longint'(x_d2[ch])
          - a1 * longint'(y_d1[ch]) - a2 * longint'(y_d2[ch]);
      // round half up, then floor by the fraction bits
      y = (acc + HALF) >>> FRAC;
      if (y > Y_MAX) y = Y_MAX;
      if (y < Y_MIN) y = Y_MIN;
      res.sample = y[23:0];
      x_d2[ch]   = x_d1[ch];
      x_d1[ch]   = x;
      y_d2[ch]   = y_d1[ch];
      y_d1[ch]   = res.sample;
    end
    expected_q.push_back(res);
  endfunction

  function void match_filtered(logic [2:0] ch, logic signed [23:0] y);
    filtered_t exp_res;
    if (expected_q.size() == 0) begin
      $error("unexpected result: channel_out %0d sample_out %0d", ch, y);
      failures++;
      return;
    end
    exp_res = expected_q.pop_front();
    if (ch !== exp_res.channel) begin
      $error("channel_out: expected %0d, actual %0d", exp_res.channel, ch);
      failures++;
    end
    if (y !== exp_res.sample) begin
      $error("sample_out: expected %0d, actual %0d", exp_res.sample, y);
      failures++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bqlp_pkg::*;

  localparam int DATA_W      = 24;
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_B = 3'd7;
  localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic signed [23:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SMP_MIN = 24'sh800000;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [2:0]              in_tuser;   // channel
  logic [DATA_W-1:0]       in_tdata;   // sample_in
  logic                    out_tvalid;
  logic                    out_tready;
  logic [2:0]              out_tuser;  // channel_out
  logic [DATA_W-1:0]       out_tdata;  // sample_out
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [COEF_BITS-1:0]    cfg_data;

  biquad_checker sb = new();
  int            results_seen = 0;
  int            burst_left   = 0;
  logic [2:0]    last_ch      = '0;

  always #5 clk = ~clk;

  biquad_lowpass_filter_bank_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // called at a falling edge; returns at a falling edge with valid low
  task automatic push_sample(logic [2:0] ch, logic signed [23:0] smp);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
    in_tuser  = ch;
    in_tdata  = smp;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.take_sample(ch, smp);
    last_ch = ch;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_coef(logic [CFG_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.load_coef(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drain the pipeline before touching coefficients
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic load_bank(coef_bank_t bank);
    settle();
    write_coef(REG_GYRO_B0,  bank.gyro.b0);
    write_coef(REG_GYRO_A1,  bank.gyro.a1);
    write_coef(REG_GYRO_A2,  bank.gyro.a2);
    write_coef(REG_ACCEL_B0, bank.accel.b0);
    write_coef(REG_ACCEL_A1, bank.accel.a1);
    write_coef(REG_ACCEL_A2, bank.accel.a2);
  endtask

  // mostly valid channels, with repeats (RAW hazard) and round-robin runs
  function automatic logic [2:0] next_channel();
    int r;
    r = $urandom_range(0, 31);
    if (r == 0) return 3'($urandom_range(6, 7));
    if (r <= 6) return (last_ch < 6) ? last_ch : 3'd0;
    if (r <= 12) return (last_ch < 5) ? last_ch + 3'd1 : 3'd0;
    return 3'($urandom_range(0, 5));
  endfunction

  function automatic logic signed [23:0] pick_sample();
    logic [31:0] rv;
    int          r;
    rv = $urandom();
    r  = $urandom_range(0, 15);
    case (r)
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return '0;
      3, 4, 5, 6: return 24'(int'($urandom_range(0, 8191)) - 4096);
      default: return rv[23:0];
    endcase
  endfunction

  function automatic coef_bank_t random_bank(bit wide);
    coef_bank_t  b;
    logic [31:0] r1, r2;
    r1 = $urandom();
    r2 = $urandom();
    b.gyro.b0  = 27'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    b.gyro.a1  = wide ? r1[26:0] : 27'(int'($urandom_range(0, 1 << 24)) - (1 << 25));
    b.gyro.a2  = 27'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
    b.accel.b0 = 27'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    b.accel.a1 = wide ? r2[26:0] : 27'(int'($urandom_range(0, 1 << 24)) - (1 << 25));
    b.accel.a2 = 27'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
    return b;
  endfunction

  task automatic run_random(int n);
    logic [2:0]         ch;
    logic signed [23:0] smp;
    repeat (n) begin
      ch  = next_channel();
      smp = pick_sample();
      push_sample(ch, smp);
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.match_filtered(out_tuser, out_tdata[23:0]);
      results_seen++;
    end
  end

  // receiver: rotating stall patterns, one long hold-off to back up the input
  initial begin : receiver
    int stall_cyc;
    bit held;
    stall_cyc  = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall_cyc++;
      if (!held && results_seen >= HOLD_AT) begin
        held       = 1'b1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      case ((stall_cyc / 400) % 4)
        0:       out_tready = 1'b1;
        1:       out_tready = ($urandom_range(0, 3) != 0);
        2:       out_tready = ((stall_cyc % 7) < 4);
        default: out_tready = 1'($urandom_range(0, 1));
      endcase
    end
  end

  // watchdog on cycles without any handshake
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
          || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("biquad_lowpass_filter_bank_top: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] rv;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = '0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: every channel at both extremes, incl. out-of-range channels
    for (int c = 0; c < 8; c++) push_sample(3'(c), SMP_MAX);
    for (int c = 0; c < 8; c++) push_sample(3'(c), SMP_MIN);
    push_sample(3'd2, '0);
    push_sample(3'd4, -24'sd1);
    push_sample(3'd5, 24'sd1);
    // back-to-back on one channel
    push_sample(3'd0, 24'sd65536);
    push_sample(3'd0, 24'sd65536);
    push_sample(3'd0, -24'sd65536);
    run_random(400);

    // largest gains: output saturates both ways
    load_bank({6{COEF_MAX}});
    push_sample(3'd0, SMP_MAX);
    push_sample(3'd3, SMP_MIN);
    push_sample(3'd0, SMP_MAX);
    push_sample(3'd7, SMP_MAX);
    run_random(200);

    load_bank({6{COEF_MIN}});
    run_random(200);

    // writes to unused indexes must leave the restored defaults alone
    load_bank(COEF_RST);
    rv = $urandom();
    write_coef(CFG_IDX_SPARE_A, rv[26:0]);
    rv = $urandom();
    write_coef(CFG_IDX_SPARE_B, rv[26:0]);
    run_random(150);

    for (int p = 0; p < 4; p++) begin
      load_bank(random_bank(p == 3));
      run_random(250);
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.failures == 0) begin
      $display("biquad_lowpass_filter_bank_top: match");
    end else begin
      $display("biquad_lowpass_filter_bank_top: mismatch");
    end
    $finish;
  end
endmodule
